@@ src/mfp_pkg.sv @@
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types and constants of the message frame parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

  // result event codes
  localparam logic [3:0] EV_PAYLOAD   = 4'd0;
  localparam logic [3:0] EV_UNICAST   = 4'd1;
  localparam logic [3:0] EV_BROADCAST = 4'd2;
  localparam logic [3:0] EV_UNREACH   = 4'd3;
  localparam logic [3:0] EV_LIST      = 4'd4;
  localparam logic [3:0] EV_ABORT     = 4'd5;
  localparam logic [3:0] EV_ID        = 4'd6;
  localparam logic [3:0] EV_INVALID   = 4'd7;
  localparam logic [3:0] EV_MAXCONN   = 4'd8;
  localparam logic [3:0] EV_DEST      = 4'd9;
  localparam logic [3:0] EV_EMPTY     = 4'd10;

  // frame characters
  localparam logic [7:0] CH_START  = 8'h40;  // '@'
  localparam logic [7:0] CH_END    = 8'h2E;  // '.'
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CMD_ID    = 8'h61;  // 'a'
  localparam logic [7:0] CMD_INVAL = 8'h3F;  // '?'
  localparam logic [7:0] CMD_MAXC  = 8'h6D;  // 'm'
  localparam logic [7:0] CMD_DEST  = 8'h5D;  // ']'
  localparam logic [7:0] CMD_LIST  = 8'h7D;  // '}'
  localparam logic [7:0] CMD_UNI   = 8'h3E;  // '>'
  localparam logic [7:0] CMD_BCAST = 8'h2A;  // '*'
  localparam logic [7:0] CMD_UNRCH = 8'h78;  // 'x'

  localparam logic [13:0] MAX_LEN_RST = 14'd1000;

  // result queue
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] data;
    logic       online;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;   // number of results pushed this cycle, 0..2
    res_t       res1;
    res_t       res0;
  } push_t;

endpackage

@@ src/mfp_res_fifo.sv @@
// ----------------------------------------------------------------------------
// mfp_res_fifo
// Result queue: takes up to two results per cycle, hands out one per beat.
// ----------------------------------------------------------------------------
module mfp_res_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mfp_pkg::push_t push_i,
  input  logic          pop_i,
  output mfp_pkg::res_t head_o,
  output logic          not_empty_o,
  output logic          room2_o
);

  mfp_pkg::res_t mem_q [mfp_pkg::RES_DEPTH];

  logic [mfp_pkg::RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mfp_pkg::RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                          pop;

  assign not_empty_o = (cnt_q != '0);
  assign room2_o     = (cnt_q <= mfp_pkg::RES_CNT_W'(mfp_pkg::RES_DEPTH - 2));
  assign head_o      = mem_q[rd_ptr_q];
  assign pop         = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + mfp_pkg::RES_PTR_W'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + mfp_pkg::RES_PTR_W'(pop);
    cnt_d    = cnt_q + mfp_pkg::RES_CNT_W'(push_i.cnt) - mfp_pkg::RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + mfp_pkg::RES_PTR_W'(1)] <= push_i.res1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mfp_pkg::RES_CNT_W'(mfp_pkg::RES_DEPTH))
    else $error("result queue overfilled");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == cnt_q[mfp_pkg::RES_PTR_W-1:0])
    else $error("result queue pointers out of step with count");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room2_o)
    else $error("result pushed without room for two");

endmodule

@@ src/message_frame_parser.sv @@
// ----------------------------------------------------------------------------
// message_frame_parser
// Byte-serial deframer for short and long message frames.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. Each byte is decoded against the frame state in
// the same cycle and its results go into a four-entry result queue that
// drains one result per beat. Most bytes give at most one result; the byte at
// frame position 9 of a long frame can give two (held payload byte plus the
// next one or the closing event), so the input stalls while fewer than two
// queue slots are free. Sustained rate: one byte per cycle as long as the
// output keeps up with one result per cycle.
module message_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [13:0] cfg_data_i,     // max_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // chunk_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data, [8] online, rest zero
  output logic [3:0]  m_axis_tuser,   // [3:0] event_res
  output logic        m_axis_tlast    // last
);

  logic [13:0]        max_len_q;
  logic [13:0]        pos_q, pos_d;
  logic               disc_q, disc_d;
  logic               start_ok_q, start_ok_d;
  logic [7:0]         cmd_q, cmd_d, hdr1_q, hdr1_d, hdr2_q, hdr2_d, held_q, held_d;
  logic signed [19:0] len_q, len_d;

  logic               accept;
  logic [7:0]         b;
  logic               ce;
  logic signed [8:0]  dig;
  logic signed [19:0] dig_w;
  logic               bad, done, known, len_bad, at_end;
  logic [1:0]         n;
  mfp_pkg::res_t      r [2];
  mfp_pkg::push_t     push;
  mfp_pkg::res_t      head;
  logic               room2, not_empty;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = room2;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign ce            = s_axis_tlast;
  assign dig           = $signed({b[7], b}) - 9'sd48;
  assign dig_w         = {{11{dig[8]}}, dig};
  assign len_bad       = (len_q < 20'sd1) || (len_q > $signed({6'd0, max_len_q}));
  assign at_end        = ({1'b0, pos_q} == (len_q[14:0] + 15'd8));

  always_comb begin
    known = 1'b0;
    if (cmd_q inside {mfp_pkg::CMD_UNI, mfp_pkg::CMD_BCAST, mfp_pkg::CMD_UNRCH,
                      mfp_pkg::CMD_LIST}) begin
      known = 1'b1;
    end
  end

  always_comb begin
    pos_d      = pos_q;
    disc_d     = disc_q;
    start_ok_d = start_ok_q;
    cmd_d      = cmd_q;
    hdr1_d     = hdr1_q;
    hdr2_d     = hdr2_q;
    held_d     = held_q;
    len_d      = len_q;
    bad        = 1'b0;
    done       = 1'b0;
    n          = 2'd0;
    r[0]       = '0;
    r[1]       = '0;

    if (disc_q) begin
      if (ce) begin
        disc_d = 1'b0;
        pos_d  = '0;
      end
    end else begin
      if (pos_q == 14'd0) begin
        start_ok_d = (b == mfp_pkg::CH_START);
      end else if (pos_q == 14'd1) begin
        cmd_d = b;
      end else if (pos_q == 14'd2) begin
        hdr1_d = b;
      end else if (pos_q == 14'd3) begin
        hdr2_d = b;
      end else if (pos_q == 14'd4) begin
        if (!start_ok_q) begin
          bad = 1'b1;
        end else if (b == mfp_pkg::CH_END) begin
          done = 1'b1;
          n    = 2'd1;
          case (cmd_q)
            mfp_pkg::CMD_ID:    r[0].event_res = mfp_pkg::EV_ID;
            mfp_pkg::CMD_INVAL: r[0].event_res = mfp_pkg::EV_INVALID;
            mfp_pkg::CMD_MAXC:  r[0].event_res = mfp_pkg::EV_MAXCONN;
            mfp_pkg::CMD_DEST:  r[0].event_res = mfp_pkg::EV_DEST;
            mfp_pkg::CMD_LIST:  r[0].event_res = mfp_pkg::EV_EMPTY;
            default:            n = 2'd0;
          endcase
          if (cmd_q == mfp_pkg::CMD_ID || cmd_q == mfp_pkg::CMD_DEST) begin
            r[0].data = hdr1_q;
          end
          if (cmd_q == mfp_pkg::CMD_DEST) begin
            r[0].online = (hdr1_q != mfp_pkg::CH_ZERO);
          end
        end else begin
          len_d = dig_w * 20'sd1000;
        end
      end else if (pos_q == 14'd5) begin
        len_d = len_q + dig_w * 20'sd100;
      end else if (pos_q == 14'd6) begin
        len_d = len_q + dig_w * 20'sd10;
      end else if (pos_q == 14'd7) begin
        len_d = len_q + dig_w;
      end else if (pos_q == 14'd8) begin
        held_d = b;
      end else begin
        if (pos_q == 14'd9) begin
          if (len_bad) begin
            bad = 1'b1;
          end else if (known) begin
            r[0].event_res = mfp_pkg::EV_PAYLOAD;
            r[0].data      = held_q;
            n              = 2'd1;
          end
        end
        if (!bad) begin
          if (at_end) begin
            if (b == mfp_pkg::CH_END) begin
              done = 1'b1;
              if (known) begin
                case (cmd_q)
                  mfp_pkg::CMD_UNI: begin
                    r[n[0]].event_res = mfp_pkg::EV_UNICAST;
                    r[n[0]].data      = hdr2_q;
                  end
                  mfp_pkg::CMD_BCAST: begin
                    r[n[0]].event_res = mfp_pkg::EV_BROADCAST;
                    r[n[0]].data      = hdr2_q;
                  end
                  mfp_pkg::CMD_UNRCH: begin
                    r[n[0]].event_res = mfp_pkg::EV_UNREACH;
                    r[n[0]].data      = hdr1_q;
                  end
                  default: r[n[0]].event_res = mfp_pkg::EV_LIST;
                endcase
                n = n + 2'd1;
              end
            end else begin
              bad = 1'b1;
              if (known) begin
                r[n[0]].event_res = mfp_pkg::EV_ABORT;
                n = n + 2'd1;
              end
            end
          end else if (known) begin
            r[n[0]].event_res = mfp_pkg::EV_PAYLOAD;
            r[n[0]].data      = b;
            n = n + 2'd1;
          end
        end
      end

      if (bad) begin
        pos_d  = '0;
        disc_d = !ce;
      end else if (done) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 14'd1;
      end
    end

    if (n == 2'd1) begin
      r[0].last = 1'b1;
    end
    if (n == 2'd2) begin
      r[1].last = 1'b1;
    end
  end

  always_comb begin
    push.cnt  = accept ? n : 2'd0;
    push.res0 = r[0];
    push.res1 = r[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= mfp_pkg::MAX_LEN_RST;
      pos_q      <= '0;
      disc_q     <= 1'b0;
      start_ok_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_data_i;
      end
      if (accept) begin
        pos_q      <= pos_d;
        disc_q     <= disc_d;
        start_ok_q <= start_ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_d;
      hdr1_q <= hdr1_d;
      hdr2_q <= hdr2_d;
      held_q <= held_d;
      len_q  <= len_d;
    end
  end

  mfp_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (m_axis_tready),
    .head_o      (head),
    .not_empty_o (not_empty),
    .room2_o     (room2)
  );

  assign m_axis_tvalid = not_empty;
  assign m_axis_tdata  = {7'd0, head.online, head.data};
  assign m_axis_tuser  = head.event_res;
  assign m_axis_tlast  = head.last;

  a_disc_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && disc_q) |-> (push.cnt == 2'd0))
    else $error("result pushed while discarding");

  a_hdr_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !disc_q && pos_q != 14'd0 && pos_q < 14'd4) |-> (push.cnt == 2'd0))
    else $error("result pushed on a header byte");

  a_disc_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && disc_q && s_axis_tlast) |=> (!disc_q && pos_q == 14'd0))
    else $error("discard did not end at chunk end");

  a_two_only_pos9: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |-> (pos_q == 14'd9))
    else $error("two results from a byte other than position 9");

endmodule
